// File: hw/rtl/ctlt_pkg.sv
// ----------------------------------------------------------------------------
// ctlt_pkg: shared types and tables for the Cyrillic-to-Latin transliterator
// Holds the queue entry format and the letter table for the 33 Cyrillic slots.
// ----------------------------------------------------------------------------
package ctlt_pkg;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CASE_OFFSET     = 8'h20;
  localparam logic [7:0] CP_YO_LOWER     = 8'hB8;
  localparam logic [7:0] CP_YO_UPPER     = 8'hA8;
  localparam logic [4:0] SLOT_YO         = 5'd6;

  // One queued job for the back end: one or two characters to emit.
  typedef struct packed {
    logic       two;
    logic [7:0] c0;
    logic [7:0] c1;
  } entry_t;

  // Table lookup result: number of letters (0..2) and the letters.
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] c0;
    logic [7:0] c1;
  } pair_t;

  function automatic pair_t mk1(input logic [7:0] c);
    pair_t p;
    p.len = 2'd1;
    p.c0  = c;
    p.c1  = 8'h00;
    return p;
  endfunction

  function automatic pair_t mk2(input logic [7:0] a, input logic [7:0] b);
    pair_t p;
    p.len = 2'd2;
    p.c0  = a;
    p.c1  = b;
    return p;
  endfunction

  // Latin letters for each slot in alphabet order, yo at slot 6.
  function automatic pair_t tl_pair(input logic [5:0] slot);
    pair_t p;
    p = '0;
    case (slot)
      6'd0:  p = mk1("a");
      6'd1:  p = mk1("b");
      6'd2:  p = mk1("v");
      6'd3:  p = mk1("g");
      6'd4:  p = mk1("d");
      6'd5:  p = mk1("e");
      6'd6:  p = mk1("e");
      6'd7:  p = mk2("z", "h");
      6'd8:  p = mk1("z");
      6'd9:  p = mk1("i");
      6'd10: p = mk1("j");
      6'd11: p = mk1("k");
      6'd12: p = mk1("l");
      6'd13: p = mk1("m");
      6'd14: p = mk1("n");
      6'd15: p = mk1("o");
      6'd16: p = mk1("p");
      6'd17: p = mk1("r");
      6'd18: p = mk1("s");
      6'd19: p = mk1("t");
      6'd20: p = mk1("u");
      6'd21: p = mk1("f");
      6'd22: p = mk1("h");
      6'd23: p = mk2("t", "c");
      6'd24: p = mk2("c", "h");
      6'd25: p = mk2("s", "h");
      6'd26: p = mk2("s", "h");
      6'd28: p = mk1("y");
      6'd30: p = mk1("e");
      6'd31: p = mk2("j", "u");
      6'd32: p = mk2("j", "a");
      default: p = '0;  // hard sign, soft sign, unused codes
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/ctlt_front.sv
// ----------------------------------------------------------------------------
// ctlt_front: input classifier
// Sorts each byte into pass-through, Cyrillic letter or separator and queues
// the characters it yields; tracks the underscore-run flag.
// ----------------------------------------------------------------------------
module ctlt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_char,
  input  logic              start_of_text,
  output logic              q_push,
  output ctlt_pkg::entry_t  q_entry,
  input  logic              q_full
);

  logic             prev_was_underscore;
  logic             prev_was_underscore_next;
  logic             accept;
  logic             prev_eff;
  logic             is_alnum;
  logic             is_cyr;
  logic             upper;
  logic [5:0]       slot;
  ctlt_pkg::pair_t  pair;
  logic [1:0]       len;
  logic [7:0]       first;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    prev_eff = start_of_text ? 1'b0 : prev_was_underscore;
    is_alnum = (in_char >= "a" && in_char <= "z") || (in_char >= "A" && in_char <= "Z") ||
               (in_char >= "0" && in_char <= "9");
    is_cyr   = (in_char == ctlt_pkg::CP_YO_LOWER) || (in_char == ctlt_pkg::CP_YO_UPPER) ||
               (in_char >= 8'hC0);
    upper    = (in_char == ctlt_pkg::CP_YO_UPPER) || (in_char[7:5] == 3'b110);
    if (in_char == ctlt_pkg::CP_YO_LOWER || in_char == ctlt_pkg::CP_YO_UPPER) begin
      slot = {1'b0, ctlt_pkg::SLOT_YO};
    end else if (in_char[4:0] < ctlt_pkg::SLOT_YO) begin
      slot = {1'b0, in_char[4:0]};
    end else begin
      slot = {1'b0, in_char[4:0]} + 6'd1;
    end
    pair  = ctlt_pkg::tl_pair(slot);
    first = upper ? (pair.c0 - ctlt_pkg::CASE_OFFSET) : pair.c0;

    prev_was_underscore_next = 1'b0;
    q_entry = '0;
    len     = 2'd0;
    if (is_alnum) begin
      len        = 2'd1;
      q_entry.c0 = in_char;
    end else if (is_cyr) begin
      len        = pair.len;
      q_entry.c0 = first;
      q_entry.c1 = pair.c1;
    end else begin
      len        = prev_eff ? 2'd0 : 2'd1;
      q_entry.c0 = ctlt_pkg::CHAR_UNDERSCORE;
      prev_was_underscore_next = 1'b1;
    end
    q_entry.two = (len == 2'd2);
    q_push      = accept && (len != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_underscore <= 1'b0;
    end else if (accept) begin
      prev_was_underscore <= prev_was_underscore_next;
    end
  end

endmodule

// File: hw/rtl/ctlt_queue.sv
// ----------------------------------------------------------------------------
// ctlt_queue: two-entry job queue
// Decouples the classifier from the character emitter.
// ----------------------------------------------------------------------------
module ctlt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  ctlt_pkg::entry_t  wr_entry,
  output logic              q_full,
  input  logic              rd,
  output logic              q_valid,
  output ctlt_pkg::entry_t  rd_entry
);

  ctlt_pkg::entry_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign q_full   = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/ctlt_back.sv
// ----------------------------------------------------------------------------
// ctlt_back: character emitter
// Steps through each queued job one character per cycle, while the output register
// is empty or being popped, and marks the last character of each job.
// ----------------------------------------------------------------------------
module ctlt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ctlt_pkg::entry_t  rd_entry,
  output logic              rd,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_char,
  output logic              last_of_run
);

  logic       out_valid;
  logic       phase;
  logic       load;
  logic       split;

  assign empty = !out_valid;
  assign load  = q_valid && (!out_valid || pop);
  assign split = rd_entry.two && !phase;
  assign rd    = load && !split;

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= phase ? rd_entry.c1 : rd_entry.c0;
      last_of_run <= !split;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= split;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/cyrillic_to_latin_transliterator.sv
// ----------------------------------------------------------------------------
// cyrillic_to_latin_transliterator: cp1251 text to Latin letters
// The first character of an item passes through the job queue and then the
// output register before it is on the result ports.
// Throughput: one result per cycle from the output register while the consumer
// pops each result; an item that yields two letters gives two results, one that yields nothing none, all others one.
// Reset (rst, synchronous): empties the job queue and output register and
// clears the underscore-run flag.
// ----------------------------------------------------------------------------
module cyrillic_to_latin_transliterator (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       start_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_of_run
);

  // Classifier to queue: a job with one or two characters. Items that yield
  // nothing (hard/soft sign, repeated separator) update the flag and drop.
  logic             q_push;
  ctlt_pkg::entry_t q_entry;
  logic             q_full;

  // Queue to emitter.
  logic             q_valid;
  logic             q_rd;
  ctlt_pkg::entry_t rd_entry;

  ctlt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_char       (in_char),
    .start_of_text (start_of_text),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .q_full        (q_full)
  );

  // Two jobs of slack let the front keep accepting while the emitter holds
  // a result the consumer has not taken yet.
  ctlt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_entry (q_entry),
    .q_full   (q_full),
    .rd       (q_rd),
    .q_valid  (q_valid),
    .rd_entry (rd_entry)
  );

  // Emitter: advance one character per transfer; release the job when its
  // last character is loaded into the output register.
  ctlt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .rd_entry    (rd_entry),
    .rd          (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule
